FILE: rtl/core/rfm_pkg.sv
`timescale 1ns / 1ps

package rfm_pkg;

  typedef enum logic [1:0] {
    REQ_PERIOD  = 2'd0,
    REQ_EDGE    = 2'd1,
    REQ_COMPUTE = 2'd2,
    REQ_NONE    = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_NEW       = 2'd0,
    ST_NOT_READY = 2'd1,
    ST_ZERO_INT  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CFG_TOP   = 2'd0,
    CFG_HZ    = 2'd1,
    CFG_WIN   = 2'd2,
    CFG_ALPHA = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    req_e        kind;
    logic [1:0]  channel;
    logic [31:0] stamp;
    logic        pending;
  } item_t;

  typedef struct packed {
    logic [31:0] period_top;
    logic [26:0] timer_clock_hz;
    logic [9:0]  window_periods;
    logic [16:0] smoothing_alpha;
  } cfg_t;

  localparam int unsigned NUM_W   = 59;
  localparam int unsigned TICKS_W = 45;
  localparam int unsigned DIV_W   = 44;
  localparam logic [10:0] PCOUNT_MAX = 11'd2047;
  localparam logic [23:0] ECOUNT_MAX = 24'hFFFFFF;
  localparam logic [16:0] ALPHA_ONE  = 17'd65536;

endpackage

FILE: rtl/core/rfm_front.sv
`timescale 1ns / 1ps

module rfm_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rfm_pkg::item_t      in_item_i,
  output logic                q_valid_o,
  input  logic                q_ready_i,
  output rfm_pkg::item_t      q_item_o
);

  rfm_pkg::item_t buf_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;

  assign in_ready_o = (count_q != 2'd2);
  assign q_valid_o  = (count_q != 2'd0);
  assign q_item_o   = buf_q[rd_ptr_q];
  // Requests of the unused kind are taken but never queued.
  assign push = in_valid_i && in_ready_o && (in_item_i.kind != rfm_pkg::REQ_NONE);
  assign pop  = q_valid_o && q_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + 2'(push) - 2'(pop);
    end
  end

endmodule

FILE: rtl/core/rfm_back.sv
`timescale 1ns / 1ps

module rfm_back #(
  parameter int CHANNELS   = 4,
  parameter int STAMP_BITS = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rfm_pkg::cfg_t  cfg_i,
  input  logic           q_valid_i,
  output logic           q_ready_o,
  input  rfm_pkg::item_t q_item_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [1:0]     out_channel_o,
  output logic [1:0]     out_status_o,
  output logic [31:0]    out_raw_o,
  output logic [31:0]    out_filt_o
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int NW   = rfm_pkg::NUM_W;
  localparam int TW   = rfm_pkg::TICKS_W;
  localparam int DW   = rfm_pkg::DIV_W;

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_CHK, S_DIV, S_F1, S_F2, S_OUT} state_e;

  state_e state_q;
  logic [1:0]            phase_q  [CHANNELS];
  logic [STAMP_BITS-1:0] first_q  [CHANNELS];
  logic [STAMP_BITS-1:0] last_q   [CHANNELS];
  logic [10:0]           pcount_q [CHANNELS];
  logic [23:0]           ecount_q [CHANNELS];
  logic [31:0]           smooth_q [CHANNELS];

  localparam logic [1:0] PH_IDLE = 2'd0, PH_START = 2'd1, PH_MEAS = 2'd2, PH_READY = 2'd3;

  logic [CH_W-1:0] idx_q;
  logic [42:0]     prod_q;
  logic [NW-1:0]   num_q;
  logic [DW-1:0]   div_q;
  logic [DW:0]     rem_q;
  logic [5:0]      cnt_q;
  logic [48:0]     p1_q, p2_q;
  logic [1:0]      res_ch_q;
  logic [1:0]      res_st_q;
  logic [31:0]     res_raw_q, res_filt_q;
  logic            out_valid_q;
  logic [1:0]      out_ch_q, out_st_q;
  logic [31:0]     out_raw_q, out_filt_q;

  logic [CH_W-1:0]       ch_idx;
  logic                  ch_ok;
  logic [9:0]            win;
  logic [10:0]           pc_sel, pc_inc;
  logic [23:0]           ec_sel;
  logic [STAMP_BITS-1:0] stamp;
  logic [TW-1:0]         ticks;
  logic [DW:0]           rem_s;
  logic                  ge;
  logic [31:0]           raw_sat;
  logic [16:0]           a_eff, a_inv;
  logic [49:0]           sum;
  logic [31:0]           filt;
  logic                  out_load;

  assign ch_idx = CH_W'(q_item_i.channel);
  assign ch_ok  = 5'(q_item_i.channel) < 5'(CHANNELS);
  assign win    = (cfg_i.window_periods == 10'd0) ? 10'd1 : cfg_i.window_periods;
  assign pc_sel = pcount_q[ch_idx];
  assign ec_sel = ecount_q[ch_idx];
  assign pc_inc = (pc_sel == rfm_pkg::PCOUNT_MAX) ? pc_sel : pc_sel + 11'd1;
  assign stamp  = q_item_i.stamp[STAMP_BITS-1:0];

  assign ticks = TW'(last_q[idx_q]) - TW'(first_q[idx_q]) + TW'(prod_q);
  assign rem_s = {rem_q[DW-1:0], num_q[NW-1]};
  assign ge    = rem_s >= {1'b0, div_q};

  assign raw_sat = (num_q[NW-1:32] != '0) ? 32'hFFFFFFFF : num_q[31:0];
  assign a_eff   = (cfg_i.smoothing_alpha > rfm_pkg::ALPHA_ONE) ? rfm_pkg::ALPHA_ONE
                                                                : cfg_i.smoothing_alpha;
  assign a_inv   = rfm_pkg::ALPHA_ONE - a_eff;
  assign sum     = 50'(p1_q) + 50'(p2_q) + 50'd32768;
  assign filt    = (sum[49:48] != 2'd0) ? 32'hFFFFFFFF : sum[47:16];

  assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  assign q_ready_o     = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign out_channel_o = out_ch_q;
  assign out_status_o  = out_st_q;
  assign out_raw_o     = out_raw_q;
  assign out_filt_o    = out_filt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        phase_q[i]  <= PH_IDLE;
        first_q[i]  <= '0;
        last_q[i]   <= '0;
        pcount_q[i] <= '0;
        ecount_q[i] <= '0;
        smooth_q[i] <= '0;
      end
    end else begin
      if (out_load) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            res_ch_q <= q_item_i.channel;
            idx_q    <= ch_idx;
            case (q_item_i.kind)
              rfm_pkg::REQ_COMPUTE: begin
                res_raw_q <= '0;
                res_st_q  <= rfm_pkg::ST_NOT_READY;
                if (!ch_ok) begin
                  res_filt_q <= '0;
                  state_q    <= S_OUT;
                end else if (phase_q[ch_idx] != PH_READY) begin
                  res_filt_q <= smooth_q[ch_idx];
                  state_q    <= S_OUT;
                end else begin
                  state_q <= S_MUL;
                end
              end
              rfm_pkg::REQ_PERIOD: begin
                if (ch_ok) begin
                  case (phase_q[ch_idx])
                    PH_IDLE: phase_q[ch_idx] <= PH_START;
                    PH_START: begin
                      pcount_q[ch_idx] <= pc_inc;
                      ecount_q[ch_idx] <= '0;
                      if (pc_inc >= 11'(win)) phase_q[ch_idx] <= PH_READY;
                    end
                    PH_MEAS: begin
                      pcount_q[ch_idx] <= pc_inc;
                      if (pc_inc >= {win, 1'b0}) phase_q[ch_idx] <= PH_READY;
                    end
                    default: ;
                  endcase
                end
              end
              rfm_pkg::REQ_EDGE: begin
                if (ch_ok && phase_q[ch_idx] == PH_START) begin
                  if (q_item_i.pending) begin
                    first_q[ch_idx]  <= '0;
                    last_q[ch_idx]   <= '0;
                    pcount_q[ch_idx] <= '0;
                    ecount_q[ch_idx] <= '0;
                    phase_q[ch_idx]  <= PH_IDLE;
                  end else begin
                    first_q[ch_idx]  <= stamp;
                    pcount_q[ch_idx] <= '0;
                    phase_q[ch_idx]  <= PH_MEAS;
                  end
                end else if (ch_ok && phase_q[ch_idx] == PH_MEAS) begin
                  // A closing edge with a period end pending aborts the window.
                  if (pc_sel >= 11'(win - 10'd1) && q_item_i.pending) begin
                    first_q[ch_idx]  <= '0;
                    last_q[ch_idx]   <= '0;
                    pcount_q[ch_idx] <= '0;
                    ecount_q[ch_idx] <= '0;
                    phase_q[ch_idx]  <= PH_IDLE;
                  end else begin
                    last_q[ch_idx] <= stamp;
                    if (ec_sel != rfm_pkg::ECOUNT_MAX) ecount_q[ch_idx] <= ec_sel + 24'd1;
                    if (pc_sel >= 11'(win - 10'd1)) phase_q[ch_idx] <= PH_READY;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        S_MUL: begin
          prod_q  <= 43'(cfg_i.period_top) * 43'(pcount_q[idx_q]);
          num_q   <= {51'(cfg_i.timer_clock_hz) * 51'(ecount_q[idx_q]), 8'd0};
          state_q <= S_CHK;
        end
        S_CHK: begin
          if (ticks[TW-1] || ticks == '0) begin
            res_st_q         <= rfm_pkg::ST_ZERO_INT;
            res_filt_q       <= smooth_q[idx_q];
            first_q[idx_q]   <= '0;
            last_q[idx_q]    <= '0;
            pcount_q[idx_q]  <= '0;
            ecount_q[idx_q]  <= '0;
            phase_q[idx_q]   <= PH_IDLE;
            state_q          <= S_OUT;
          end else begin
            div_q   <= ticks[DW-1:0];
            rem_q   <= '0;
            cnt_q   <= '0;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          rem_q <= ge ? rem_s - {1'b0, div_q} : rem_s;
          num_q <= {num_q[NW-2:0], ge};
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'(NW - 1)) state_q <= S_F1;
        end
        S_F1: begin
          res_raw_q        <= raw_sat;
          res_st_q         <= rfm_pkg::ST_NEW;
          first_q[idx_q]   <= '0;
          last_q[idx_q]    <= '0;
          pcount_q[idx_q]  <= '0;
          ecount_q[idx_q]  <= '0;
          phase_q[idx_q]   <= PH_IDLE;
          if (smooth_q[idx_q] == '0) begin
            res_filt_q      <= raw_sat;
            smooth_q[idx_q] <= raw_sat;
            state_q         <= S_OUT;
          end else begin
            p1_q    <= 49'(smooth_q[idx_q]) * 49'(a_inv);
            p2_q    <= 49'(raw_sat) * 49'(a_eff);
            state_q <= S_F2;
          end
        end
        S_F2: begin
          res_filt_q      <= filt;
          smooth_q[idx_q] <= filt;
          state_q         <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            out_ch_q    <= res_ch_q;
            out_st_q    <= res_st_q;
            out_raw_q   <= res_raw_q;
            out_filt_q  <= res_filt_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/reciprocal_frequency_meter.sv
`timescale 1ns / 1ps
// Timer period ends and capture edges are applied in the back end's idle state.
// A ready compute request runs through the multiply, check, divide and filter states; a zero
// interval exits at the check, and a zero smoothed value skips the second filter state. The
// restoring divider resolves one quotient bit per cycle over 59 bits.
// A two-entry request queue lets new requests arrive while a result waits to be taken.
// Reset is asynchronous and active low: every channel goes idle with cleared counters,
// zero smoothed value, and the configuration registers return to their default values.
module reciprocal_frequency_meter #(
  parameter int CHANNELS   = 4,
  parameter int STAMP_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // channel, capture_value, period_end_pending, zero fill
  input  logic [1:0]  s_axis_tuser,  // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,  // result_channel, raw_frequency, filtered_frequency, zeros
  output logic [1:0]  m_axis_tuser,  // status
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  rfm_pkg::cfg_t  cfg_q;
  rfm_pkg::item_t in_item, q_item;
  logic           q_valid, q_ready;
  logic [1:0]     out_ch;
  logic [31:0]    out_raw, out_filt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.period_top      <= 32'd65535;
      cfg_q.timer_clock_hz  <= 27'd1000000;
      cfg_q.window_periods  <= 10'd4;
      cfg_q.smoothing_alpha <= 17'd16384;
    end else if (cfg_we_i) begin
      case (rfm_pkg::cfg_idx_e'(cfg_idx_i))
        rfm_pkg::CFG_TOP:   cfg_q.period_top      <= cfg_data_i;
        rfm_pkg::CFG_HZ:    cfg_q.timer_clock_hz  <= cfg_data_i[26:0];
        rfm_pkg::CFG_WIN:   cfg_q.window_periods  <= cfg_data_i[9:0];
        rfm_pkg::CFG_ALPHA: cfg_q.smoothing_alpha <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  assign in_item.kind    = rfm_pkg::req_e'(s_axis_tuser);
  assign in_item.channel = s_axis_tdata[1:0];
  assign in_item.stamp   = s_axis_tdata[33:2];
  assign in_item.pending = s_axis_tdata[34];

  rfm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_item_i  (in_item),
    .q_valid_o  (q_valid),
    .q_ready_i  (q_ready),
    .q_item_o   (q_item)
  );

  rfm_back #(
    .CHANNELS   (CHANNELS),
    .STAMP_BITS (STAMP_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .q_valid_i     (q_valid),
    .q_ready_o     (q_ready),
    .q_item_i      (q_item),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_channel_o (out_ch),
    .out_status_o  (m_axis_tuser),
    .out_raw_o     (out_raw),
    .out_filt_o    (out_filt)
  );

  assign m_axis_tdata = {6'd0, out_filt, out_raw, out_ch};

endmodule

FILE: rtl/core/rfm_checker.sv
`timescale 1ns / 1ps

module rfm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser <= rfm_pkg::ST_ZERO_INT)
    else $error("result status out of range");

  a_raw_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != rfm_pkg::ST_NEW |-> m_axis_tdata[33:2] == 32'd0)
    else $error("raw frequency set on a failed request");

  a_reset: assert property (@(posedge clk_i) $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result valid out of reset");

endmodule

bind reciprocal_frequency_meter rfm_checker u_rfm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int NCH = 4;
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_START = 2'd1;
  localparam logic [1:0] PH_MEAS  = 2'd2;
  localparam logic [1:0] PH_READY = 2'd3;

  typedef struct packed {
    logic [1:0]        chan;
    rfm_pkg::status_e  status;
    logic [31:0]       raw;
    logic [31:0]       filt;
  } freq_res_t;

  // Predicts the meter from accepted requests and holds the pending results.
  class meter_scoreboard;
    logic [31:0] top;
    logic [26:0] hz;
    logic [9:0]  win;
    logic [16:0] alpha;
    logic [1:0]  ph [NCH];
    logic [31:0] first_s [NCH];
    logic [31:0] last_s [NCH];
    logic [10:0] pcnt [NCH];
    logic [23:0] ecnt [NCH];
    logic [31:0] smooth [NCH];
    freq_res_t   pending_q[$];
    int          errors;

    function void reset_state();
      top = 32'd65535; hz = 27'd1000000; win = 10'd4; alpha = 17'd16384;
      errors = 0;
      for (int i = 0; i < NCH; i++) begin
        clear_window(i);
        smooth[i] = '0;
      end
    endfunction

    function void clear_window(int c);
      first_s[c] = '0; last_s[c] = '0; pcnt[c] = '0; ecnt[c] = '0; ph[c] = PH_IDLE;
    endfunction

    function void write_reg(rfm_pkg::cfg_idx_e idx, logic [31:0] v);
      case (idx)
        rfm_pkg::CFG_TOP:   top = v;
        rfm_pkg::CFG_HZ:    hz = v[26:0];
        rfm_pkg::CFG_WIN:   win = v[9:0];
        rfm_pkg::CFG_ALPHA: alpha = v[16:0];
        default: ;
      endcase
    endfunction

    function void note_request(rfm_pkg::item_t it);
      int c;
      logic [10:0] w;
      logic signed [63:0] ticks;
      logic [127:0] raw, filt, a;
      freq_res_t r;
      c = it.channel;
      w = (win == 0) ? 11'd1 : {1'b0, win};
      case (it.kind)
        rfm_pkg::REQ_PERIOD: begin
          if (ph[c] == PH_IDLE) begin
            ph[c] = PH_START;
          end else if (ph[c] == PH_START) begin
            if (pcnt[c] < rfm_pkg::PCOUNT_MAX) pcnt[c]++;
            ecnt[c] = '0;
            if (pcnt[c] >= w) ph[c] = PH_READY;
          end else if (ph[c] == PH_MEAS) begin
            if (pcnt[c] < rfm_pkg::PCOUNT_MAX) pcnt[c]++;
            if ({1'b0, pcnt[c]} >= 2 * w) ph[c] = PH_READY;
          end
        end
        rfm_pkg::REQ_EDGE: begin
          if (ph[c] == PH_START) begin
            if (it.pending) clear_window(c);
            else begin
              first_s[c] = it.stamp; pcnt[c] = '0; ph[c] = PH_MEAS;
            end
          end else if (ph[c] == PH_MEAS) begin
            last_s[c] = it.stamp;
            if (ecnt[c] < rfm_pkg::ECOUNT_MAX) ecnt[c]++;
            if (pcnt[c] >= w - 1) begin
              if (it.pending) clear_window(c);
              else ph[c] = PH_READY;
            end
          end
        end
        rfm_pkg::REQ_COMPUTE: begin
          r.chan = it.channel;
          r.raw = '0;
          if (ph[c] != PH_READY) begin
            r.status = rfm_pkg::ST_NOT_READY;
            r.filt = smooth[c];
          end else begin
            ticks = $signed({32'd0, last_s[c]}) - $signed({32'd0, first_s[c]})
                  + $signed(64'(top) * 64'(pcnt[c]));
            if (ticks <= 0) begin
              clear_window(c);
              r.status = rfm_pkg::ST_ZERO_INT;
              r.filt = smooth[c];
            end else begin
              raw = (128'(hz) * 128'(ecnt[c]) * 128'd256) / 128'(ticks);
              if (raw > 128'hFFFFFFFF) raw = 128'hFFFFFFFF;
              clear_window(c);
              if (smooth[c] == 0) filt = raw;
              else begin
                a = (alpha > rfm_pkg::ALPHA_ONE) ? 128'd65536 : 128'(alpha);
                filt = (128'(smooth[c]) * (128'd65536 - a) + raw * a + 128'd32768) >> 16;
                if (filt > 128'hFFFFFFFF) filt = 128'hFFFFFFFF;
              end
              smooth[c] = filt[31:0];
              r.status = rfm_pkg::ST_NEW;
              r.raw = raw[31:0];
              r.filt = filt[31:0];
            end
          end
          pending_q.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void check_result(freq_res_t got);
      freq_res_t e;
      if (pending_q.size() == 0) begin
        $error("result with nothing expected: ch=%0d", got.chan);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (got.chan !== e.chan) begin
        $error("result_channel exp %0d got %0d", e.chan, got.chan); errors++;
      end
      if (got.status !== e.status) begin
        $error("status exp %0d got %0d", e.status, got.status); errors++;
      end
      if (got.raw !== e.raw) begin
        $error("raw_frequency exp %0h got %0h", e.raw, got.raw); errors++;
      end
      if (got.filt !== e.filt) begin
        $error("filtered_frequency exp %0h got %0h", e.filt, got.filt); errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;

  meter_scoreboard freq_sb;
  bit hold_sink = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  reciprocal_frequency_meter u_top (.*);

  task automatic write_reg(rfm_pkg::cfg_idx_e idx, logic [31:0] v);
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    freq_sb.write_reg(idx, v);
  endtask

  // The valid line stays high after a request is taken so that the next one can follow
  // without a gap; a gap, a drain or a register write lowers it.
  task automatic send_request(rfm_pkg::req_e kind, logic [1:0] ch, logic [31:0] stamp,
                              logic pend, bit gaps = 1'b1);
    int gap;
    rfm_pkg::item_t it;
    gap = gaps ? $urandom_range(0, 9) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    it.kind = kind; it.channel = ch; it.stamp = stamp; it.pending = pend;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {5'd0, pend, stamp, ch};
    do @(posedge clk_i); while (!s_axis_tready);
    freq_sb.note_request(it);
    @(negedge clk_i);
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (freq_sb.pending_q.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
  endtask

  // A well-formed window: start, first edge, some edges and periods, closing edge, compute.
  task automatic send_window(logic [1:0] ch, int nper, int nedge);
    logic [31:0] t;
    t = $urandom;
    send_request(rfm_pkg::REQ_PERIOD, ch, $urandom, 1'($urandom));
    send_request(rfm_pkg::REQ_EDGE, ch, t, 1'b0);
    for (int i = 0; i < nper; i++) begin
      for (int j = 0; j < nedge; j++) begin
        t = t + $urandom_range(1, 5000);
        send_request(rfm_pkg::REQ_EDGE, ch, t, ($urandom_range(0, 19) == 0));
      end
      send_request(rfm_pkg::REQ_PERIOD, ch, $urandom, 1'($urandom));
    end
    send_request(rfm_pkg::REQ_EDGE, ch, $urandom, ($urandom_range(0, 9) == 0));
    send_request(rfm_pkg::REQ_COMPUTE, ch, $urandom, 1'($urandom));
  endtask

  task automatic random_config();
    write_reg(rfm_pkg::CFG_TOP,
              ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 70000));
    write_reg(rfm_pkg::CFG_HZ, $urandom_range(1, 100000000));
    write_reg(rfm_pkg::CFG_WIN, $urandom_range(0, 3));
    write_reg(rfm_pkg::CFG_ALPHA,
              $urandom_range(0, 3) == 0 ? 32'h1FFFF : $urandom_range(0, 65536));
  endtask

  // Receiver: random stalls, one long hold-off on request.
  initial begin
    freq_res_t got;
    forever begin
      @(negedge clk_i);
      if (hold_sink) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(negedge clk_i);
        hold_sink = 1'b0;
      end
      m_axis_tready <= ($urandom_range(0, 3) == 0) ? 1'b1 : ($urandom_range(0, 9) < 4);
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got.chan = m_axis_tdata[1:0];
        got.raw = m_axis_tdata[33:2];
        got.filt = m_axis_tdata[65:34];
        got.status = rfm_pkg::status_e'(m_axis_tuser);
        freq_sb.check_result(got);
      end
    end
  end

  initial begin
    freq_sb = new();
    freq_sb.reset_state();
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // Directed: not ready, unknown type, extremes, aborts, zero interval, saturation.
    send_request(rfm_pkg::REQ_COMPUTE, 2'd0, 32'hFFFFFFFF, 1'b1);
    send_request(rfm_pkg::REQ_NONE, 2'd3, 32'hFFFFFFFF, 1'b1);
    wait_drain();
    write_reg(rfm_pkg::CFG_WIN, 32'd1);
    send_request(rfm_pkg::REQ_PERIOD, 2'd1, '0, 1'b0);
    send_request(rfm_pkg::REQ_EDGE, 2'd1, 32'd5, 1'b1);
    send_request(rfm_pkg::REQ_PERIOD, 2'd2, '0, 1'b0);
    send_request(rfm_pkg::REQ_EDGE, 2'd2, 32'd100, 1'b0);
    send_request(rfm_pkg::REQ_EDGE, 2'd2, 32'd100, 1'b0);
    send_request(rfm_pkg::REQ_COMPUTE, 2'd2, '0, 1'b0);
    send_request(rfm_pkg::REQ_PERIOD, 2'd3, '0, 1'b0);
    send_request(rfm_pkg::REQ_EDGE, 2'd3, 32'd0, 1'b0);
    send_request(rfm_pkg::REQ_EDGE, 2'd3, 32'hFFFFFFFF, 1'b0);
    send_request(rfm_pkg::REQ_COMPUTE, 2'd3, '0, 1'b0);
    send_request(rfm_pkg::REQ_PERIOD, 2'd0, '0, 1'b0);
    send_request(rfm_pkg::REQ_PERIOD, 2'd0, '0, 1'b0);
    send_request(rfm_pkg::REQ_COMPUTE, 2'd0, '0, 1'b0);
    wait_drain();
    write_reg(rfm_pkg::CFG_TOP, 32'd1);
    write_reg(rfm_pkg::CFG_HZ, 32'd100000000);
    write_reg(rfm_pkg::CFG_ALPHA, 32'd65536);
    send_request(rfm_pkg::REQ_PERIOD, 2'd3, '0, 1'b0);
    send_request(rfm_pkg::REQ_EDGE, 2'd3, 32'd7, 1'b0);
    send_request(rfm_pkg::REQ_EDGE, 2'd3, 32'd8, 1'b0);
    send_request(rfm_pkg::REQ_COMPUTE, 2'd3, '0, 1'b0);
    wait_drain();
    write_reg(rfm_pkg::CFG_WIN, 32'd1023);
    write_reg(rfm_pkg::CFG_TOP, 32'hFFFFFFFF);
    write_reg(rfm_pkg::CFG_ALPHA, 32'd0);
    send_window(2'd1, 3, 1);
    send_request(rfm_pkg::REQ_COMPUTE, 2'd1, '0, 1'b0);
    wait_drain();

    // Back-to-back computes with the receiver held off, so the input stalls.
    hold_sink = 1'b1;
    for (int i = 0; i < 12; i++)
      send_request(rfm_pkg::REQ_COMPUTE, 2'(i), $urandom, 1'b0, 1'b0);
    wait_drain();

    for (int p = 0; p < 8; p++) begin
      random_config();
      for (int k = 0; k < 8; k++) begin
        if ($urandom_range(0, 4) == 0) begin
          for (int n = 0; n < 6; n++)
            send_request(rfm_pkg::req_e'($urandom_range(0, 3)), 2'($urandom), $urandom,
                         1'($urandom));
        end else begin
          send_window(2'($urandom), $urandom_range(0, 4), $urandom_range(0, 2));
        end
      end
      wait_drain();
    end
    if (freq_sb.errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: files.f
rtl/core/rfm_pkg.sv
rtl/core/rfm_front.sv
rtl/core/rfm_back.sv
rtl/core/reciprocal_frequency_meter.sv
rtl/core/rfm_checker.sv
verif/tb_top.sv
